[sv/amiv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// amiv_pkg
// Shared types and the multiply-accumulate schedule for the affine inverse.
// ----------------------------------------------------------------------------
package amiv_pkg;

  localparam int NUM_ENTRIES = 12;
  localparam int NUM_ADJ     = 9;
  localparam int NUM_OPS     = 30;

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_MUL  = 4'b0010,
    BK_DIV  = 4'b0100,
    BK_EMIT = 4'b1000
  } bk_state_t;

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_PREP = 4'b0010,
    DV_RUN  = 4'b0100,
    DV_FIN  = 4'b1000
  } dv_state_t;

  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_ADJ  = 2'd1,
    DST_DET  = 2'd2,
    DST_T    = 2'd3
  } dst_t;

  typedef struct packed {
    logic [3:0] a_idx;
    logic       b_adj;
    logic [3:0] b_idx;
    logic       sub;
    logic       first;
    logic       last;
    dst_t       dst;
    logic [3:0] dst_idx;
  } mac_op_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

  function automatic mac_op_t mk(input logic [3:0] a, input logic badj, input logic [3:0] b,
                                 input logic sub, input logic first, input logic last,
                                 input dst_t dst, input logic [3:0] di);
    mac_op_t o;
    o.a_idx   = a;
    o.b_adj   = badj;
    o.b_idx   = b;
    o.sub     = sub;
    o.first   = first;
    o.last    = last;
    o.dst     = dst;
    o.dst_idx = di;
    return o;
  endfunction

  // Entry m[i][j] lives at index 4*i+j, adjugate entry adj[i][j] at 3*i+j.
  // Each cofactor is a product minus a product; the determinant expands row 0;
  // the translation sums adjugate row times the old translation column.
  function automatic mac_op_t op_of(input logic [4:0] s);
    mac_op_t o;
    case (s)
      5'd0:  o = mk(4'd5, 1'b0, 4'd10, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd1:  o = mk(4'd6, 1'b0, 4'd9,  1'b1, 1'b0, 1'b1, DST_ADJ,  4'd0);
      5'd2:  o = mk(4'd2, 1'b0, 4'd9,  1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd3:  o = mk(4'd1, 1'b0, 4'd10, 1'b1, 1'b0, 1'b1, DST_ADJ,  4'd1);
      5'd4:  o = mk(4'd1, 1'b0, 4'd6,  1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd5:  o = mk(4'd2, 1'b0, 4'd5,  1'b1, 1'b0, 1'b1, DST_ADJ,  4'd2);
      5'd6:  o = mk(4'd6, 1'b0, 4'd8,  1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd7:  o = mk(4'd4, 1'b0, 4'd10, 1'b1, 1'b0, 1'b1, DST_ADJ,  4'd3);
      5'd8:  o = mk(4'd0, 1'b0, 4'd10, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd9:  o = mk(4'd2, 1'b0, 4'd8,  1'b1, 1'b0, 1'b1, DST_ADJ,  4'd4);
      5'd10: o = mk(4'd2, 1'b0, 4'd4,  1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd11: o = mk(4'd0, 1'b0, 4'd6,  1'b1, 1'b0, 1'b1, DST_ADJ,  4'd5);
      5'd12: o = mk(4'd4, 1'b0, 4'd9,  1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd13: o = mk(4'd5, 1'b0, 4'd8,  1'b1, 1'b0, 1'b1, DST_ADJ,  4'd6);
      5'd14: o = mk(4'd1, 1'b0, 4'd8,  1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd15: o = mk(4'd0, 1'b0, 4'd9,  1'b1, 1'b0, 1'b1, DST_ADJ,  4'd7);
      5'd16: o = mk(4'd0, 1'b0, 4'd5,  1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd17: o = mk(4'd1, 1'b0, 4'd4,  1'b1, 1'b0, 1'b1, DST_ADJ,  4'd8);
      5'd18: o = mk(4'd0, 1'b1, 4'd0,  1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd19: o = mk(4'd1, 1'b1, 4'd3,  1'b0, 1'b0, 1'b0, DST_NONE, 4'd0);
      5'd20: o = mk(4'd2, 1'b1, 4'd6,  1'b0, 1'b0, 1'b1, DST_DET,  4'd0);
      5'd21: o = mk(4'd3,  1'b1, 4'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd22: o = mk(4'd7,  1'b1, 4'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 4'd0);
      5'd23: o = mk(4'd11, 1'b1, 4'd2, 1'b0, 1'b0, 1'b1, DST_T,    4'd0);
      5'd24: o = mk(4'd3,  1'b1, 4'd3, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd25: o = mk(4'd7,  1'b1, 4'd4, 1'b0, 1'b0, 1'b0, DST_NONE, 4'd0);
      5'd26: o = mk(4'd11, 1'b1, 4'd5, 1'b0, 1'b0, 1'b1, DST_T,    4'd1);
      5'd27: o = mk(4'd3,  1'b1, 4'd6, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      5'd28: o = mk(4'd7,  1'b1, 4'd7, 1'b0, 1'b0, 1'b0, DST_NONE, 4'd0);
      5'd29: o = mk(4'd11, 1'b1, 4'd8, 1'b0, 1'b0, 1'b1, DST_T,    4'd2);
      default: o = mk(4'd0, 1'b0, 4'd0, 1'b0, 1'b1, 1'b1, DST_NONE, 4'd0);
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

[sv/affine_matrix_inverse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Inverse of an affine 3x4 matrix in signed fixed point, one row per transfer.
// ----------------------------------------------------------------------------
// Usage: one s_tdata transfer carries the twelve entries e00..e23, row by row,
// each DATA_WIDTH bits with FRAC_BITS fraction bits. Each matrix gives three
// m_tdata transfers, rows 0, 1 and 2, with m_tlast on row 2. m_tuser flags a
// singular matrix (identity returned) and a clamped entry in the row.
// det_threshold is written through cfg_wen/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A bit-serial multiply-accumulate unit runs 30 products; then, unless the
// matrix is singular, a one-bit-per-cycle divider forms each of the twelve
// entries, and each row is emitted through the output register. The next
// matrix is taken from the queue only once row 2 is in the output register.
// A two-entry input queue accepts further matrices while one is computed, and
// an output register holds a row while the receiver stalls.
// Reset empties the queue and output, and sets det_threshold to 4295.
// ----------------------------------------------------------------------------
module affine_matrix_inverse #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wen,
  input  wire logic [31:0]                          cfg_wdata,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // e00, e01, e02, e03, e10, ..., e23 from bit 0 up, zero padded to bytes.
  input  wire logic [((12*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // row_index, c0, c1, c2, c3 from bit 0 up, zero padded to bytes.
  output logic [((2+4*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
  output logic                                      m_tlast,
  // singular, saturated from bit 0 up.
  output logic [1:0]                                m_tuser
);

  localparam int IW  = 12 * DATA_WIDTH;
  localparam int OTW = ((2 + 4 * DATA_WIDTH + 7) / 8) * 8;

  logic [31:0]           det_threshold;
  logic                  q_valid;
  logic                  q_ready;
  logic [IW-1:0]         q_data;
  logic [1:0]            o_row;
  logic [DATA_WIDTH-1:0] o_c [4];
  logic                  o_sing;
  logic                  o_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= 32'd4295;
    end else if (cfg_wen) begin
      det_threshold <= cfg_wdata;
    end
  end

  amiv_front #(
    .IW (IW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_data   (s_tdata[IW-1:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  amiv_back #(
    .DW (DATA_WIDTH),
    .F  (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .thr     (det_threshold),
    .o_valid (m_tvalid),
    .o_ready (m_tready),
    .o_row   (o_row),
    .o_c     (o_c),
    .o_last  (m_tlast),
    .o_sing  (o_sing),
    .o_sat   (o_sat)
  );

  assign m_tdata = OTW'({o_c[3], o_c[2], o_c[1], o_c[0], o_row});
  assign m_tuser = {o_sat, o_sing};

endmodule
`default_nettype wire

[sv/amiv_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// amiv_front
// Input side: takes matrix transfers and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module amiv_front #(
  parameter int IW = 384
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [IW-1:0] s_data,
  output logic               q_valid,
  input  wire logic          q_ready,
  output logic [IW-1:0]      q_data
);

  logic [IW-1:0] mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;

  assign s_tready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = mem[rp];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= s_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/amiv_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// amiv_div
// Restoring divider: signed quotient rounded to nearest (ties away from zero)
// and clamped to DW bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amiv_div #(
  parameter int DW   = 32,
  parameter int NUMW = 132,
  parameter int DENW = 99
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [NUMW-1:0] num,
  input  wire logic signed [DENW-1:0] den,
  output logic [DW-1:0]               q,
  output amiv_pkg::div_stat_t         stat
);

  localparam int N2W = NUMW + 2;
  localparam int RW  = DENW + 2;
  localparam int CW  = $clog2(DW);
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  amiv_pkg::dv_state_t st;
  logic [NUMW-1:0] absn;
  logic [DENW-1:0] absd;
  logic            neg;
  logic [RW-1:0]   rem;
  logic [DENW:0]   d2;
  logic [DW-1:0]   nlow;
  logic [DW-1:0]   qr;
  logic            ovf;
  logic [CW-1:0]   cnt;
  logic            fin;
  logic            sat;

  logic [N2W-1:0]  n2;
  logic [N2W-1:0]  hi;
  logic [DENW:0]   d2v;
  logic [RW-1:0]   remsh;
  logic            ge;
  logic            negq;

  // The rounded quotient is floor((2|n| + |d|) / (2|d|)).
  assign d2v   = {absd, 1'b0};
  assign n2    = N2W'({absn, 1'b0}) + N2W'(absd);
  assign hi    = n2 >> DW;
  assign remsh = {rem[RW-2:0], nlow[DW-1]};
  assign ge    = (remsh >= RW'(d2));
  assign negq  = neg && (ovf || (qr != '0));
  assign stat  = '{done: fin, sat: sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= amiv_pkg::DV_IDLE;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      case (st)
        amiv_pkg::DV_IDLE: begin
          if (start) begin
            st <= amiv_pkg::DV_PREP;
          end
        end
        amiv_pkg::DV_PREP: begin
          st <= amiv_pkg::DV_RUN;
        end
        amiv_pkg::DV_RUN: begin
          if (cnt == CW'(DW - 1)) begin
            st <= amiv_pkg::DV_FIN;
          end
        end
        amiv_pkg::DV_FIN: begin
          st  <= amiv_pkg::DV_IDLE;
          fin <= 1'b1;
        end
        default: st <= amiv_pkg::DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      amiv_pkg::DV_IDLE: begin
        absn <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
        absd <= den[DENW-1] ? DENW'(-den) : DENW'(den);
        neg  <= num[NUMW-1] ^ den[DENW-1];
      end
      amiv_pkg::DV_PREP: begin
        // A high part at or above the divisor means the quotient needs more
        // than DW bits, which always clamps.
        ovf  <= (hi >= N2W'(d2v));
        rem  <= RW'(hi);
        nlow <= n2[DW-1:0];
        d2   <= d2v;
        qr   <= '0;
        cnt  <= '0;
      end
      amiv_pkg::DV_RUN: begin
        rem  <= ge ? (remsh - RW'(d2)) : remsh;
        qr   <= {qr[DW-2:0], ge};
        nlow <= {nlow[DW-2:0], 1'b0};
        cnt  <= cnt + CW'(1);
      end
      amiv_pkg::DV_FIN: begin
        if (ovf) begin
          q   <= negq ? MINV : MAXV;
          sat <= 1'b1;
        end else if (!negq) begin
          q   <= qr[DW-1] ? MAXV : qr;
          sat <= qr[DW-1];
        end else if (qr[DW-1] && (qr[DW-2:0] != '0)) begin
          q   <= MINV;
          sat <= 1'b1;
        end else begin
          q   <= -qr;
          sat <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[sv/amiv_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// amiv_back
// Execution side: serial multiply-accumulate for adjugate, determinant and
// translation, then twelve divisions (skipped for a singular matrix) and the row output register.
// ----------------------------------------------------------------------------
module amiv_back #(
  parameter int DW = 32,
  parameter int F  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire logic [12*DW-1:0]   q_data,
  input  wire logic [31:0]        thr,
  output logic                    o_valid,
  input  wire logic               o_ready,
  output logic [1:0]              o_row,
  output logic [DW-1:0]           o_c [4],
  output logic                    o_last,
  output logic                    o_sing,
  output logic                    o_sat
);

  localparam int AW   = 3 * DW + 3;
  localparam int CW   = 2 * DW + 1;
  localparam int NUMW = AW + 2 * F + 1;
  localparam int BCW  = $clog2(DW);
  localparam int SW   = AW + 3 * F + 33;
  localparam logic ONE_SAT = (F >= DW - 1);
  localparam logic [DW-1:0] ONE_VAL =
    (F >= DW - 1) ? {1'b0, {(DW-1){1'b1}}} : (DW'(1) << F);

  amiv_pkg::bk_state_t state;
  amiv_pkg::mac_op_t   op;
  amiv_pkg::div_stat_t dstat;

  logic signed [DW-1:0] m   [amiv_pkg::NUM_ENTRIES];
  logic signed [CW-1:0] adj [amiv_pkg::NUM_ADJ];
  logic signed [AW-1:0] tv  [3];
  logic signed [AW-1:0] det;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] bsh;
  logic [DW-1:0]        amul;
  logic [4:0]           step;
  logic                 mrun;
  logic [BCW-1:0]       bcnt;
  logic [1:0]           row;
  logic [1:0]           col;
  logic                 dwait;
  logic                 sing;
  logic [DW-1:0]        rowc [4];
  logic                 rowsat;

  logic [3:0]             adj_addr;
  logic signed [CW-1:0]   adj_rd;
  logic signed [AW-1:0]   b_val;
  logic                   last_bit;
  logic                   neg_term;
  logic signed [AW-1:0]   term;
  logic signed [AW-1:0]   acc_nx;
  logic signed [NUMW-1:0] dnum;
  logic                   dstart;
  logic [DW-1:0]          dq;
  logic [AW-1:0]          absdet;
  logic                   is_sing;
  logic                   out_free;
  logic                   emit;

  assign op       = amiv_pkg::op_of(step);
  assign adj_addr = (state == amiv_pkg::BK_MUL) ? op.b_idx
                                                : (4'(row) * 4'd3 + 4'(col));
  assign adj_rd   = adj[adj_addr];
  assign b_val    = op.b_adj ? AW'(adj_rd) : AW'(m[op.b_idx]);
  assign last_bit = (bcnt == BCW'(DW - 1));
  // The multiplier's top bit carries negative weight.
  assign neg_term = op.sub ^ last_bit;
  assign term     = amul[0] ? (neg_term ? -bsh : bsh) : '0;
  assign acc_nx   = acc + term;

  assign dnum = (col == 2'd3) ? -(NUMW'(tv[row]) <<< F) : (NUMW'(adj_rd) <<< (2 * F));
  assign dstart = (state == amiv_pkg::BK_DIV) && !dwait;

  assign absdet  = det[AW-1] ? AW'(-det) : AW'(det);
  assign is_sing = (det == '0) || ((SW'(absdet) << 32) < (SW'(thr) << (3 * F)));

  assign q_ready  = (state == amiv_pkg::BK_IDLE);
  assign out_free = !o_valid || o_ready;
  assign emit     = (state == amiv_pkg::BK_EMIT) && out_free;

  amiv_div #(
    .DW   (DW),
    .NUMW (NUMW),
    .DENW (AW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (dnum),
    .den   (det),
    .q     (dq),
    .stat  (dstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= amiv_pkg::BK_IDLE;
      mrun    <= 1'b0;
      dwait   <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (o_ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        amiv_pkg::BK_IDLE: begin
          if (q_valid) begin
            state <= amiv_pkg::BK_MUL;
            mrun  <= 1'b0;
          end
        end
        amiv_pkg::BK_MUL: begin
          if (!mrun) begin
            mrun <= 1'b1;
          end else if (last_bit) begin
            mrun <= 1'b0;
            if (step == 5'(amiv_pkg::NUM_OPS - 1)) begin
              state <= is_sing ? amiv_pkg::BK_EMIT : amiv_pkg::BK_DIV;
            end
          end
        end
        amiv_pkg::BK_DIV: begin
          if (dstart) begin
            dwait <= 1'b1;
          end else if (dstat.done) begin
            dwait <= 1'b0;
            if (col == 2'd3) begin
              state <= amiv_pkg::BK_EMIT;
            end
          end
        end
        amiv_pkg::BK_EMIT: begin
          if (out_free) begin
            if (row == 2'd2) begin
              state <= amiv_pkg::BK_IDLE;
            end else begin
              state <= sing ? amiv_pkg::BK_EMIT : amiv_pkg::BK_DIV;
            end
          end
        end
        default: state <= amiv_pkg::BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      amiv_pkg::BK_IDLE: begin
        for (int i = 0; i < amiv_pkg::NUM_ENTRIES; i++) begin
          m[i] <= q_data[i*DW +: DW];
        end
        step <= '0;
      end
      amiv_pkg::BK_MUL: begin
        if (!mrun) begin
          bsh  <= b_val;
          amul <= m[op.a_idx];
          bcnt <= '0;
          if (op.first) begin
            acc <= '0;
          end
        end else begin
          acc  <= acc_nx;
          bsh  <= bsh <<< 1;
          amul <= amul >> 1;
          bcnt <= bcnt + BCW'(1);
          if (last_bit) begin
            step <= step + 5'd1;
            case (op.dst)
              amiv_pkg::DST_ADJ: adj[op.dst_idx] <= CW'(acc_nx);
              amiv_pkg::DST_DET: det <= acc_nx;
              amiv_pkg::DST_T:   tv[op.dst_idx[1:0]] <= acc_nx;
              default: ;
            endcase
            if (step == 5'(amiv_pkg::NUM_OPS - 1)) begin
              sing   <= is_sing;
              row    <= 2'd0;
              col    <= 2'd0;
              rowsat <= 1'b0;
            end
          end
        end
      end
      amiv_pkg::BK_DIV: begin
        if (!dstart && dstat.done) begin
          rowc[col] <= dq;
          rowsat    <= rowsat | dstat.sat;
          col       <= col + 2'd1;
        end
      end
      amiv_pkg::BK_EMIT: begin
        if (out_free) begin
          o_row  <= row;
          o_last <= (row == 2'd2);
          o_sing <= sing;
          if (sing) begin
            for (int j = 0; j < 3; j++) begin
              o_c[j] <= (row == 2'(j)) ? ONE_VAL : '0;
            end
            o_c[3] <= '0;
            o_sat  <= ONE_SAT;
          end else begin
            for (int j = 0; j < 4; j++) begin
              o_c[j] <= rowc[j];
            end
            o_sat <= rowsat;
          end
          row    <= row + 2'd1;
          col    <= 2'd0;
          rowsat <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[sv/amiv_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// amiv_check
// Port-level checks on the affine inverse output stream.
// ----------------------------------------------------------------------------
module amiv_check #(
  parameter int DW = 32
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [((2+4*DW+7)/8)*8-1:0]       m_tdata,
  input wire logic                              m_tlast,
  input wire logic [1:0]                        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd2)))
    else $error("tlast does not match row 2");

  a_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("row index out of range");

  a_sing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[2+4*DW-1 -: DW] == '0))
    else $error("singular row has nonzero translation");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("stream not empty after reset");

endmodule

bind affine_matrix_inverse amiv_check #(
  .DW (DATA_WIDTH)
) u_amiv_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire
